### design/etl_pkg.sv
package etl_pkg;

    // Sizes
    localparam int MAX_NODES = 1024;
    localparam int MAX_TOUR  = 2048;
    localparam int LEVELS    = 11;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int POS_W   = $clog2(MAX_TOUR);
    localparam int LEN_W   = POS_W + 1;
    localparam int LVL_W   = $clog2(LEVELS);
    localparam int NADR_W  = $clog2(MAX_NODES);
    localparam int ST_AW   = LVL_W + POS_W;
    localparam int ST_DEPTH = LEVELS * MAX_TOUR;

    // Actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_BUILD = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_BUILD = 2'd2;
    localparam logic [1:0] ST_UNSEEN   = 2'd3;

    // Datapath operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_SWEEP   = 4'd1;
    localparam logic [3:0] OP_LOAD_RD = 4'd2;
    localparam logic [3:0] OP_LOAD_WR = 4'd3;
    localparam logic [3:0] OP_B_INIT  = 4'd4;
    localparam logic [3:0] OP_B_L0    = 4'd5;
    localparam logic [3:0] OP_B_RD    = 4'd6;
    localparam logic [3:0] OP_B_DRD   = 4'd7;
    localparam logic [3:0] OP_B_WR    = 4'd8;
    localparam logic [3:0] OP_B_NEXT  = 4'd9;
    localparam logic [3:0] OP_B_DONE  = 4'd10;
    localparam logic [3:0] OP_Q_RD    = 4'd11;
    localparam logic [3:0] OP_Q_CALC  = 4'd12;
    localparam logic [3:0] OP_Q_ST    = 4'd13;
    localparam logic [3:0] OP_Q_DEP   = 4'd14;
    localparam logic [3:0] OP_Q_NODE  = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic       capture;
        logic       anc_take;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic row_last;
        logic lv_last;
        logic len_zero;
        logic top_zero;
        logic q_bad;
        logic out_free;
    } sts_t;

    // Index of highest set bit, zero for zero
    function automatic logic [LVL_W-1:0] floor_log2(input logic [LEN_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int k = 0; k < LEN_W; k++)
        begin
            if (v[k])
            begin
                r = LVL_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] cap_level(input logic [LVL_W-1:0] lv);
        logic [LVL_W-1:0] top;
        top = LVL_W'(LEVELS - 1);
        return (lv > top) ? top : lv;
    endfunction

endpackage

### design/etl_if.sv
interface etl_in_if;
    import etl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [NODE_W-1:0]    node_a;
    logic [DEPTH_W-1:0]   entry_depth;
    logic [NODE_W-1:0]    node_b;

    modport source (output valid, action, node_a, entry_depth, node_b, input ready);
    modport sink   (input valid, action, node_a, entry_depth, node_b, output ready);
endinterface

interface etl_out_if;
    import etl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [NODE_W-1:0]    ancestor_node;
    logic [POS_W-1:0]     ancestor_position;
    logic [1:0]           status;

    modport source (output valid, ancestor_node, ancestor_position, status, input ready);
    modport sink   (input valid, ancestor_node, ancestor_position, status, output ready);
endinterface

### design/euler_tour_lca_sparse_table.sv
// Channel  Dir  Fields
// req      in   action, node_a, entry_depth, node_b
// rsp      out  ancestor_node, ancestor_position, status
//
// One item at a time. A clear sweeps one seen-flag entry a cycle; a build does
// a registered table read, depth read and write per entry of each upper level.
// After reset a sweep clears all the seen flags; req.ready stays low.
// A result waits in the output register; a following word is still taken.
module euler_tour_lca_sparse_table (
    input  logic      clk,
    input  logic      rst_n,
    etl_in_if.sink    req,
    etl_out_if.source rsp
);
    import etl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    etl_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    etl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .node_a      (req.node_a),
        .entry_depth (req.entry_depth),
        .node_b      (req.node_b),
        .cmd         (cmd),
        .sts         (sts),
        .rsp         (rsp)
    );

endmodule

### design/etl_ctrl.sv
module etl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic [1:0]    req_action,
    output logic          req_ready,
    input  etl_pkg::sts_t sts,
    output etl_pkg::cmd_t cmd
);
    import etl_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RSWEEP  = 4'd1;
    localparam logic [3:0] S_CSWEEP  = 4'd2;
    localparam logic [3:0] S_LOAD_RD = 4'd3;
    localparam logic [3:0] S_LOAD_WR = 4'd4;
    localparam logic [3:0] S_B_INIT  = 4'd5;
    localparam logic [3:0] S_B_L0    = 4'd6;
    localparam logic [3:0] S_B_RD    = 4'd7;
    localparam logic [3:0] S_B_DRD   = 4'd8;
    localparam logic [3:0] S_B_WR    = 4'd9;
    localparam logic [3:0] S_B_NEXT  = 4'd10;
    localparam logic [3:0] S_B_DONE  = 4'd11;
    localparam logic [3:0] S_Q_RD    = 4'd12;
    localparam logic [3:0] S_Q_CALC  = 4'd13;
    localparam logic [3:0] S_Q_ST    = 4'd14;
    localparam logic [3:0] S_Q_MID   = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       node_reg, node_next;   // query tail: pick and node read
    logic       take_reg, take_next;   // query tail: answer node taken
    logic       fin_reg, fin_next;     // waiting to hand result to output

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RSWEEP;
            node_reg  <= 1'b0;
            take_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg  <= node_next;
            take_reg  <= take_next;
            fin_reg   <= fin_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE) && !fin_reg && !node_reg && !take_reg;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        node_next    = node_reg;
        take_next    = take_reg;
        fin_next     = fin_reg;
        cmd.op       = OP_NONE;
        cmd.capture  = 1'b0;
        cmd.anc_take = 1'b0;
        cmd.finish   = 1'b0;
        if (fin_reg)
        begin
            if (sts.out_free)
            begin
                cmd.finish = 1'b1;
                fin_next   = 1'b0;
            end
        end
        else if (take_reg)
        begin
            cmd.anc_take = 1'b1;
            take_next    = 1'b0;
            fin_next     = 1'b1;
        end
        else if (node_reg)
        begin
            cmd.op    = OP_Q_NODE;
            node_next = 1'b0;
            take_next = 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd.capture = 1'b1;
                        case (req_action)
                            ACT_CLEAR: state_next = S_CSWEEP;
                            ACT_LOAD:  state_next = S_LOAD_RD;
                            ACT_BUILD: state_next = S_B_INIT;
                            default:   state_next = S_Q_RD;
                        endcase
                    end
                end
                S_RSWEEP:
                begin
                    cmd.op = OP_SWEEP;
                    if (sts.sweep_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                S_CSWEEP:
                begin
                    cmd.op = OP_SWEEP;
                    if (sts.sweep_last)
                    begin
                        state_next = S_IDLE;
                        fin_next   = 1'b1;
                    end
                end
                S_LOAD_RD:
                begin
                    cmd.op     = OP_LOAD_RD;
                    state_next = S_LOAD_WR;
                end
                S_LOAD_WR:
                begin
                    cmd.op     = OP_LOAD_WR;
                    state_next = S_IDLE;
                    fin_next   = 1'b1;
                end
                S_B_INIT:
                begin
                    cmd.op     = OP_B_INIT;
                    state_next = sts.len_zero ? S_B_DONE : S_B_L0;
                end
                S_B_L0:
                begin
                    cmd.op = OP_B_L0;
                    if (sts.row_last)
                    begin
                        state_next = sts.top_zero ? S_B_DONE : S_B_NEXT;
                    end
                end
                S_B_NEXT:
                begin
                    cmd.op     = OP_B_NEXT;
                    state_next = S_B_RD;
                end
                S_B_RD:
                begin
                    cmd.op     = OP_B_RD;
                    state_next = S_B_DRD;
                end
                S_B_DRD:
                begin
                    cmd.op     = OP_B_DRD;
                    state_next = S_B_WR;
                end
                S_B_WR:
                begin
                    cmd.op = OP_B_WR;
                    if (!sts.row_last)
                    begin
                        state_next = S_B_RD;
                    end
                    else
                    begin
                        state_next = sts.lv_last ? S_B_DONE : S_B_NEXT;
                    end
                end
                S_B_DONE:
                begin
                    cmd.op     = OP_B_DONE;
                    state_next = S_IDLE;
                    fin_next   = 1'b1;
                end
                S_Q_RD:
                begin
                    cmd.op     = OP_Q_RD;
                    state_next = S_Q_CALC;
                end
                S_Q_CALC:
                begin
                    cmd.op = OP_Q_CALC;
                    if (sts.q_bad)
                    begin
                        state_next = S_IDLE;
                        fin_next   = 1'b1;
                    end
                    else
                    begin
                        state_next = S_Q_ST;
                    end
                end
                S_Q_ST:
                begin
                    cmd.op     = OP_Q_ST;
                    state_next = S_Q_MID;
                end
                S_Q_MID:
                begin
                    // depth read, then pick and node lookup in the tail
                    cmd.op     = OP_Q_DEP;
                    state_next = S_IDLE;
                    node_next  = 1'b1;
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/etl_dp.sv
module etl_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [etl_pkg::NODE_W-1:0] node_a,
    input  logic [etl_pkg::DEPTH_W-1:0] entry_depth,
    input  logic [etl_pkg::NODE_W-1:0] node_b,
    input  etl_pkg::cmd_t              cmd,
    output etl_pkg::sts_t              sts,
    etl_out_if.source                  rsp
);
    import etl_pkg::*;

    // Memories
    logic [NODE_W-1:0]  tour_node_mem  [0:MAX_TOUR-1];
    logic [DEPTH_W-1:0] tour_depth_mem [0:MAX_TOUR-1];
    logic [POS_W-1:0]   st_mem         [0:ST_DEPTH-1];
    logic [POS_W:0]     fp_mem         [0:MAX_NODES-1];   // {seen, first position}

    // Control registers
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              built_reg, built_next;
    logic [NADR_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]  i_reg, i_next;
    logic [LVL_W-1:0]  lv_reg, lv_next;
    logic [LVL_W-1:0]  top_reg, top_next;
    logic              out_valid_reg, out_valid_next;

    // Payload registers
    logic [NODE_W-1:0]  na_reg, nb_reg;
    logic [DEPTH_W-1:0] dep_reg;
    logic [POS_W-1:0]   lo_reg, rs_reg;
    logic [LVL_W-1:0]   lvq_reg;
    logic [NODE_W-1:0]  res_anc_reg, out_anc_reg;
    logic [POS_W-1:0]   res_pos_reg, out_pos_reg;
    logic [1:0]         res_sts_reg, out_sts_reg;
    logic [POS_W:0]     fp_rd0, fp_rd1;
    logic [POS_W-1:0]   st_rd0, st_rd1;
    logic [DEPTH_W-1:0] dep_rd0, dep_rd1;
    logic [NODE_W-1:0]  node_rd;

    logic               do_query_tail;
    logic [POS_W-1:0]   pick;
    logic [LEN_W-1:0]   pair_idx;
    logic [POS_W-1:0]   right_idx;
    logic [POS_W-1:0]   lo_c, hi_c, diff_c;
    logic [LVL_W-1:0]   lvq_c;
    logic [LEN_W-1:0]   rs_c;
    logic               unseen_c;

    // Shallower of two candidates, right one on a tie
    assign pick = (dep_rd0 < dep_rd1) ? st_rd0 : st_rd1;

    // Partner index for the build
    assign pair_idx  = {1'b0, i_reg} + (LEN_W'(1) << (lv_reg - LVL_W'(1)));
    assign right_idx = (pair_idx < len_reg) ? pair_idx[POS_W-1:0] : i_reg;

    // Query window
    assign unseen_c = !fp_rd0[POS_W] || !fp_rd1[POS_W];
    assign lo_c     = (fp_rd1[POS_W-1:0] < fp_rd0[POS_W-1:0]) ?
                      fp_rd1[POS_W-1:0] : fp_rd0[POS_W-1:0];
    assign hi_c     = (fp_rd1[POS_W-1:0] < fp_rd0[POS_W-1:0]) ?
                      fp_rd0[POS_W-1:0] : fp_rd1[POS_W-1:0];
    assign diff_c   = hi_c - lo_c;
    assign lvq_c    = cap_level(floor_log2({1'b0, diff_c}));
    assign rs_c     = {1'b0, hi_c} + LEN_W'(1) - (LEN_W'(1) << lvq_c);

    assign do_query_tail = (cmd.op == OP_Q_NODE);

    // Status to controller
    assign sts.sweep_last = (cnt_reg == NADR_W'(MAX_NODES - 1));
    assign sts.row_last   = ({1'b0, i_reg} == len_reg - LEN_W'(1));
    assign sts.lv_last    = (lv_reg == top_reg);
    assign sts.len_zero   = (len_reg == '0);
    assign sts.top_zero   = (cap_level(floor_log2(len_reg)) == '0) || (top_reg == '0);
    assign sts.q_bad      = !built_reg || unseen_c;
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    // Control register updates
    always_comb
    begin
        len_next       = len_reg;
        built_next     = built_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        lv_next        = lv_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        case (cmd.op)
            OP_SWEEP:
            begin
                cnt_next   = cnt_reg + NADR_W'(1);
                len_next   = '0;
                built_next = 1'b0;
            end
            OP_LOAD_WR:
            begin
                if (len_reg < LEN_W'(MAX_TOUR))
                begin
                    len_next   = len_reg + LEN_W'(1);
                    built_next = 1'b0;
                end
            end
            OP_B_INIT:
            begin
                i_next   = '0;
                lv_next  = '0;
                top_next = cap_level(floor_log2(len_reg));
            end
            OP_B_L0, OP_B_WR:
            begin
                i_next = i_reg + POS_W'(1);
            end
            OP_B_NEXT:
            begin
                i_next  = '0;
                lv_next = lv_reg + LVL_W'(1);
            end
            OP_B_DONE:
            begin
                built_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            built_reg     <= 1'b0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            lv_reg        <= '0;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            built_reg     <= built_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            lv_reg        <= lv_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Word capture, result fields and output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            na_reg      <= node_a;
            nb_reg      <= node_b;
            dep_reg     <= entry_depth;
            res_anc_reg <= '0;
            res_pos_reg <= '0;
            res_sts_reg <= ST_OK;
        end
        if (cmd.op == OP_LOAD_WR && len_reg >= LEN_W'(MAX_TOUR))
        begin
            res_sts_reg <= ST_FULL;
        end
        if (cmd.op == OP_Q_CALC)
        begin
            lo_reg  <= lo_c;
            rs_reg  <= rs_c[POS_W-1:0];
            lvq_reg <= lvq_c;
            if (!built_reg)
            begin
                res_sts_reg <= ST_NO_BUILD;
            end
            else if (unseen_c)
            begin
                res_sts_reg <= ST_UNSEEN;
            end
        end
        if (do_query_tail)
        begin
            res_pos_reg <= pick;
        end
        if (cmd.anc_take)
        begin
            res_anc_reg <= node_rd;
        end
        if (cmd.finish)
        begin
            out_anc_reg <= res_anc_reg;
            out_pos_reg <= res_pos_reg;
            out_sts_reg <= res_sts_reg;
        end
    end

    // First-position store
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SWEEP)
        begin
            fp_mem[cnt_reg] <= '0;
        end
        else if (cmd.op == OP_LOAD_WR && len_reg < LEN_W'(MAX_TOUR) && !fp_rd0[POS_W])
        begin
            fp_mem[na_reg] <= {1'b1, len_reg[POS_W-1:0]};
        end
        if (cmd.op == OP_LOAD_RD || cmd.op == OP_Q_RD)
        begin
            fp_rd0 <= fp_mem[na_reg];
        end
        if (cmd.op == OP_Q_RD)
        begin
            fp_rd1 <= fp_mem[nb_reg];
        end
    end

    // Tour store
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD_WR && len_reg < LEN_W'(MAX_TOUR))
        begin
            tour_node_mem[len_reg[POS_W-1:0]]  <= na_reg;
            tour_depth_mem[len_reg[POS_W-1:0]] <= dep_reg;
        end
        if (cmd.op == OP_B_DRD || cmd.op == OP_Q_DEP)
        begin
            dep_rd0 <= tour_depth_mem[st_rd0];
            dep_rd1 <= tour_depth_mem[st_rd1];
        end
        if (do_query_tail)
        begin
            node_rd <= tour_node_mem[pick];
        end
    end

    // Sparse table store
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_B_L0)
        begin
            st_mem[{LVL_W'(0), i_reg}] <= i_reg;
        end
        else if (cmd.op == OP_B_WR)
        begin
            st_mem[{lv_reg, i_reg}] <= pick;
        end
        if (cmd.op == OP_B_RD)
        begin
            st_rd0 <= st_mem[{lv_reg - LVL_W'(1), i_reg}];
            st_rd1 <= st_mem[{lv_reg - LVL_W'(1), right_idx}];
        end
        else if (cmd.op == OP_Q_ST)
        begin
            st_rd0 <= st_mem[{lvq_reg, lo_reg}];
            st_rd1 <= st_mem[{lvq_reg, rs_reg}];
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.ancestor_node     = out_anc_reg;
    assign rsp.ancestor_position = out_pos_reg;
    assign rsp.status            = out_sts_reg;

    // Checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_TOUR))
        else $error("tour length beyond capacity");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || rsp.ready))
        else $error("result overwrote a waiting word");
    a_top_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_B_INIT) |=> (top_reg <= LVL_W'(LEVELS - 1)))
        else $error("build level above table height");

endmodule

### dv/euler_tour_lca_sparse_table_test.sv
`timescale 1ns / 100ps

module euler_tour_lca_sparse_table_test;
    import etl_pkg::*;

    logic clk;
    logic rst_n;

    etl_in_if  req ();
    etl_out_if rsp ();

    euler_tour_lca_sparse_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    typedef struct {
        logic [NODE_W-1:0] node;
        logic [POS_W-1:0]  pos;
        logic [1:0]        status;
    } answer_t;

    typedef struct {
        logic [1:0]         action;
        logic [NODE_W-1:0]  a;
        logic [DEPTH_W-1:0] d;
        logic [NODE_W-1:0]  b;
        bit                 typed;
        answer_t            ans;
    } vector_t;

    // Mirror of the block's tour, table and seen flags
    logic [NODE_W-1:0]  tour_nodes [MAX_TOUR];
    logic [DEPTH_W-1:0] tour_depths [MAX_TOUR];
    int                 rmq [LEVELS][MAX_TOUR];
    int                 first_at [MAX_NODES];
    bit                 visited [MAX_NODES];
    int                 tour_len;
    bit                 built;

    answer_t answers_due [$];
    int      errors;
    int      src_idle;
    int      dst_idle;
    int      hold_cycles;
    bit      hold_req;
    bit      typed_next;
    answer_t typed_ans;

    // Clock: period 20 ns
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int msb_index(input int v);
        int r;
        r = 0;
        while (v > 1)
        begin
            v = v >> 1;
            r++;
        end
        return (r > LEVELS - 1) ? LEVELS - 1 : r;
    endfunction

    // Right-hand position wins on equal depth
    function automatic int shallower(input int l, input int r);
        return (tour_depths[l] < tour_depths[r]) ? l : r;
    endfunction

    function automatic void lca_reset();
        foreach (visited[i])
            visited[i] = 1'b0;
        tour_len = 0;
        built    = 1'b0;
    endfunction

    function automatic answer_t lca_step(input logic [1:0] action, input logic [NODE_W-1:0] a,
                                         input logic [DEPTH_W-1:0] d,
                                         input logic [NODE_W-1:0] b);
        answer_t r;
        int      lo;
        int      hi;
        int      t;
        int      lv;
        int      half;
        r = '{default: '0};
        case (action)
            ACT_CLEAR:
            begin
                lca_reset();
            end
            ACT_LOAD:
            begin
                if (tour_len >= MAX_TOUR)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    tour_nodes[tour_len]  = a;
                    tour_depths[tour_len] = d;
                    if (!visited[a])
                    begin
                        first_at[a] = tour_len;
                        visited[a]  = 1'b1;
                    end
                    tour_len++;
                    built = 1'b0;
                end
            end
            ACT_BUILD:
            begin
                if (tour_len != 0)
                begin
                    for (int i = 0; i < tour_len; i++)
                        rmq[0][i] = i;
                    t = msb_index(tour_len);
                    for (lv = 1; lv <= t; lv++)
                    begin
                        half = 1 << (lv - 1);
                        for (int i = 0; i < tour_len; i++)
                            rmq[lv][i] = (i + half < tour_len) ?
                                shallower(rmq[lv-1][i], rmq[lv-1][i+half]) : rmq[lv-1][i];
                    end
                end
                built = 1'b1;
            end
            default:
            begin
                if (!built)
                begin
                    r.status = ST_NO_BUILD;
                end
                else if (!visited[a] || !visited[b])
                begin
                    r.status = ST_UNSEEN;
                end
                else
                begin
                    lo = first_at[a];
                    hi = first_at[b];
                    if (hi < lo)
                    begin
                        t  = lo;
                        lo = hi;
                        hi = t;
                    end
                    if (lo == hi)
                    begin
                        t = lo;
                    end
                    else
                    begin
                        lv = msb_index(hi - lo);
                        t  = shallower(rmq[lv][lo], rmq[lv][hi + 1 - (1 << lv)]);
                    end
                    r.pos  = POS_W'(t);
                    r.node = tour_nodes[t];
                end
            end
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Offer one word from a falling edge; returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] action, input logic [NODE_W-1:0] a,
                             input logic [DEPTH_W-1:0] d, input logic [NODE_W-1:0] b);
        answer_t e;
        while ($urandom_range(99, 0) < src_idle)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid       = 1'b1;
        req.action      = action;
        req.node_a      = a;
        req.entry_depth = d;
        req.node_b      = b;
        do
            @(posedge clk);
        while (!req.ready);
        e = lca_step(action, a, d, b);
        if (typed_next)
            e = typed_ans;
        typed_next = 1'b0;
        answers_due.push_back(e);
        @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_cycles = 400;
            hold_req    = 1'b0;
        end
        if (hold_cycles > 0)
        begin
            rsp.ready = 1'b0;
            hold_cycles--;
        end
        else
        begin
            rsp.ready = ($urandom_range(99, 0) >= dst_idle);
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answers_due.size() == 0)
            begin
                report("unexpected word", rsp.status, 0);
            end
            else
            begin
                e = answers_due.pop_front();
                if (rsp.ancestor_node !== e.node)
                    report("ancestor_node", rsp.ancestor_node, e.node);
                if (rsp.ancestor_position !== e.pos)
                    report("ancestor_position", rsp.ancestor_position, e.pos);
                if (rsp.status !== e.status)
                    report("status", rsp.status, e.status);
            end
        end
    end

    // One well-formed tour from a random walk, then build and queries
    task automatic random_tree();
        logic [NODE_W-1:0] path [$];
        logic [NODE_W-1:0] labels [$];
        logic [NODE_W-1:0] lbl;
        int                steps;
        int                nq;
        send_word(ACT_CLEAR, NODE_W'($urandom), DEPTH_W'($urandom), NODE_W'($urandom));
        lbl = NODE_W'($urandom);
        path.push_back(lbl);
        labels.push_back(lbl);
        send_word(ACT_LOAD, lbl, DEPTH_W'(0), NODE_W'($urandom));
        steps = $urandom_range(40, 1);
        for (int s = 0; s < steps; s++)
        begin
            if (path.size() > 1 && $urandom_range(1, 0))
            begin
                void'(path.pop_back());
            end
            else
            begin
                lbl = NODE_W'($urandom);
                path.push_back(lbl);
                labels.push_back(lbl);
            end
            send_word(ACT_LOAD, path[$], DEPTH_W'(path.size() - 1), NODE_W'($urandom));
        end
        // Occasionally query before the build
        if ($urandom_range(3, 0) == 0)
            send_word(ACT_QUERY, labels[0], DEPTH_W'($urandom), labels[$]);
        send_word(ACT_BUILD, NODE_W'($urandom), DEPTH_W'($urandom), NODE_W'($urandom));
        nq = $urandom_range(15, 3);
        for (int q = 0; q < nq; q++)
        begin
            if ($urandom_range(9, 0) == 0)
                send_word(ACT_QUERY, NODE_W'($urandom), DEPTH_W'($urandom),
                          labels[$urandom_range(labels.size() - 1, 0)]);
            else
                send_word(ACT_QUERY, labels[$urandom_range(labels.size() - 1, 0)],
                          DEPTH_W'($urandom), labels[$urandom_range(labels.size() - 1, 0)]);
        end
        // Noise: a stray load, queries and a rebuild
        if ($urandom_range(4, 0) == 0)
        begin
            send_word(ACT_LOAD, NODE_W'($urandom), DEPTH_W'($urandom), NODE_W'($urandom));
            send_word(ACT_QUERY, labels[0], DEPTH_W'($urandom), labels[$]);
            send_word(ACT_BUILD, NODE_W'($urandom), DEPTH_W'($urandom), NODE_W'($urandom));
            send_word(ACT_QUERY, labels[0], DEPTH_W'($urandom), NODE_W'($urandom));
        end
    endtask

    vector_t directed [] = '{
        '{ACT_QUERY, 10'd0,    10'd0,    10'd0,    1, '{10'd0, 11'd0, ST_NO_BUILD}},
        '{ACT_BUILD, 10'd1023, 10'd1023, 10'd1023, 1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd1,    10'd2,    10'd3,    1, '{10'd0, 11'd0, ST_UNSEEN}},
        '{ACT_LOAD,  10'd1023, 10'd1023, 10'd0,    1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_LOAD,  10'd0,    10'd0,    10'd1023, 1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_LOAD,  10'd5,    10'd1023, 10'd682,  1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_LOAD,  10'd1023, 10'd512,  10'd341,  1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_LOAD,  10'd682,  10'd341,  10'd0,    1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_LOAD,  10'd341,  10'd682,  10'd0,    0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_BUILD, 10'd0,    10'd0,    10'd0,    0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd1023, 10'd0,    10'd0,    0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd0,    10'd1023, 10'd1023, 0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd1023, 10'd0,    10'd1023, 1, '{10'd1023, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd5,    10'd0,    10'd682,  0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd341,  10'd0,    10'd5,    0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd2,    10'd0,    10'd3,    1, '{10'd0, 11'd0, ST_UNSEEN}},
        '{ACT_QUERY, 10'd1023, 10'd0,    10'd4,    1, '{10'd0, 11'd0, ST_UNSEEN}},
        '{ACT_LOAD,  10'd7,    10'd0,    10'd0,    1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd7,    10'd0,    10'd1023, 1, '{10'd0, 11'd0, ST_NO_BUILD}},
        '{ACT_BUILD, 10'd0,    10'd0,    10'd0,    0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd7,    10'd0,    10'd1023, 0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd682,  10'd0,    10'd7,    0, '{10'd0, 11'd0, ST_OK}},
        '{ACT_CLEAR, 10'd1023, 10'd1023, 10'd1023, 1, '{10'd0, 11'd0, ST_OK}},
        '{ACT_QUERY, 10'd0,    10'd0,    10'd0,    1, '{10'd0, 11'd0, ST_NO_BUILD}}
    };

    // Safety limit
    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int waited;
        errors          = 0;
        src_idle        = 20;
        dst_idle        = 84;
        hold_cycles     = 0;
        hold_req        = 1'b0;
        typed_next      = 1'b0;
        req.valid       = 1'b0;
        req.action      = ACT_CLEAR;
        req.node_a      = '0;
        req.entry_depth = '0;
        req.node_b      = '0;
        rsp.ready       = 1'b0;
        lca_reset();
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            typed_next = directed[i].typed;
            typed_ans  = directed[i].ans;
            send_word(directed[i].action, directed[i].a, directed[i].d, directed[i].b);
        end

        // Three idling phases of random trees
        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle = (ph == 0) ? 20 : (ph == 1) ? 84 : 0;
            dst_idle = (ph == 0) ? 84 : (ph == 1) ? 20 : 0;
            if (ph == 2)
                hold_req = 1'b1;
            for (int t = 0; t < 6; t++)
                random_tree();
        end
        req.valid = 1'b0;

        waited = 0;
        while (answers_due.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        if (answers_due.size() != 0)
            report("words still due", answers_due.size(), 0);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
